[rtl/eitc_pkg.sv]
// Shared types, constants and helper functions for the Ethernet/IPv4/TCP header checker.
`timescale 1ns / 1ps
package eitc_pkg;

    localparam int unsigned CNT_W = 17;
    localparam logic [CNT_W-1:0] CNT_MAX = 17'h1FFFF;
    localparam logic [CNT_W-1:0] ETH_HDR_BYTES = 17'd14;
    localparam logic [CNT_W-1:0] MIN_HDR_BYTES = 17'd20;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [7:0] LOOPBACK_NET = 8'h7F;
    localparam logic [15:0] CSUM_GOOD = 16'hFFFF;

    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_IP_CSUM_EN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TCP_CSUM_EN = 8'd1;

    localparam int unsigned IN_TDATA_W = 32;
    localparam int unsigned OUT_TDATA_W = 88;

    typedef enum logic [3:0] {
        ST_TCP_OK        = 4'd0,
        ST_FRAG_OK       = 4'd1,
        ST_CAP_GT_WIRE   = 4'd2,
        ST_SHORT_ETH     = 4'd3,
        ST_NOT_IPV4      = 4'd4,
        ST_SHORT_IP      = 4'd5,
        ST_BAD_IHL       = 4'd6,
        ST_LEN_MISMATCH  = 4'd7,
        ST_LAND          = 4'd8,
        ST_LOOPBACK      = 4'd9,
        ST_IP_CSUM       = 4'd10,
        ST_UNSUPP_PROTO  = 4'd11,
        ST_SHORT_TCP     = 4'd12,
        ST_BAD_OFFSET    = 4'd13,
        ST_OFFSET_GT_LEN = 4'd14,
        ST_TCP_CSUM      = 4'd15
    } t_status;

    // Everything the verdict needs, captured at the last byte of a frame.
    typedef struct packed {
        logic [CNT_W-1:0] cap;
        logic [CNT_W-1:0] wire_len;
        logic [15:0]      ether_kind;
        logic [3:0]       ihl;
        logic [15:0]      total_len;
        logic [15:0]      frag_word;
        logic [7:0]       proto;
        logic [31:0]      src_addr;
        logic [31:0]      dst_addr;
        logic [15:0]      ip_sum;
        logic [15:0]      tcp_sum;
        logic [3:0]       thw;
        logic [31:0]      ports;
        logic [7:0]       held;
    } t_snap;

    typedef struct packed {
        t_status          status;
        logic [15:0]      src_port;
        logic [15:0]      dst_port;
        logic [12:0]      frag_off;
        logic             rsv_flag;
        logic             dont_frag;
        logic             more_frag;
        logic             fragmented;
        logic [CNT_W-1:0] pay_off;
        logic [15:0]      pay_len;
    } t_result;

    // Ones'-complement add with end-around carry.
    function automatic logic [15:0] oc_add(input logic [15:0] s, input logic [15:0] w);
        logic [16:0] t;
        begin
            t = {1'b0, s} + {1'b0, w};
            oc_add = t[15:0] + {15'd0, t[16]};
        end
    endfunction

endpackage

[rtl/eitc_hdr_acc.sv]
// Per-byte header capture and running checksums, with the end-of-frame snapshot register.
`timescale 1ns / 1ps
module eitc_hdr_acc (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [7:0]             i_byte,
    input  logic [eitc_pkg::CNT_W-1:0] i_wire_len,
    input  logic                   i_last,
    input  logic                   i_adv,
    output logic                   o_ready,
    output logic                   o_snap_valid,
    output eitc_pkg::t_snap        o_snap
);
    import eitc_pkg::*;

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_fwl, n_fwl;
    logic [15:0] r_eth, n_eth;
    logic [3:0]  r_ihl, n_ihl;
    logic [15:0] r_tot, n_tot;
    logic [15:0] r_frag, n_frag;
    logic [7:0]  r_proto, n_proto;
    logic [31:0] r_sa, n_sa;
    logic [31:0] r_da, n_da;
    logic [15:0] r_ipsum, n_ipsum;
    logic [15:0] r_tcpsum, n_tcpsum;
    logic [3:0]  r_thw, n_thw;
    logic [31:0] r_ports, n_ports;
    logic [7:0]  r_held, n_held;
    logic        r_snap_valid;
    t_snap       r_snap;

    logic             accept;
    logic [CNT_W-1:0] base;
    logic [CNT_W-1:0] tofs;
    logic             in_tcp;
    logic             in_ip;
    logic [15:0]      word;

    assign o_ready      = !r_snap_valid || i_adv;
    assign accept       = i_valid && o_ready;
    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

    always_comb begin
        n_fwl   = (r_cnt == '0) ? i_wire_len : r_fwl;
        n_eth   = (r_cnt == 17'd12 || r_cnt == 17'd13) ? {r_eth[7:0], i_byte} : r_eth;
        n_ihl   = (r_cnt == 17'd14) ? i_byte[3:0] : r_ihl;
        n_tot   = (r_cnt == 17'd16 || r_cnt == 17'd17) ? {r_tot[7:0], i_byte} : r_tot;
        n_frag  = (r_cnt == 17'd20 || r_cnt == 17'd21) ? {r_frag[7:0], i_byte} : r_frag;
        n_proto = (r_cnt == 17'd23) ? i_byte : r_proto;
        n_sa    = (r_cnt >= 17'd26 && r_cnt <= 17'd29) ? {r_sa[23:0], i_byte} : r_sa;
        n_da    = (r_cnt >= 17'd30 && r_cnt <= 17'd33) ? {r_da[23:0], i_byte} : r_da;

        // The IP header length in force includes this byte's update.
        base   = ETH_HDR_BYTES + {11'd0, n_ihl, 2'b00};
        in_tcp = (r_cnt >= base);
        in_ip  = (r_cnt >= ETH_HDR_BYTES) && (r_cnt < base);
        tofs   = r_cnt - base;

        n_ports = (in_tcp && tofs < 17'd4) ? {r_ports[23:0], i_byte} : r_ports;
        n_thw   = (in_tcp && tofs == 17'd12) ? i_byte[7:4] : r_thw;

        word     = {r_held, i_byte};
        n_ipsum  = r_ipsum;
        n_tcpsum = r_tcpsum;
        n_held   = r_held;
        if (r_cnt[0]) begin
            if (in_ip) begin
                n_ipsum = oc_add(r_ipsum, word);
            end else if (in_tcp) begin
                n_tcpsum = oc_add(r_tcpsum, word);
            end
        end else begin
            n_held = i_byte;
        end

        n_cnt = (r_cnt < CNT_MAX) ? r_cnt + 17'd1 : r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_fwl <= '0; r_eth <= '0; r_ihl <= '0; r_tot <= '0;
            r_frag <= '0; r_proto <= '0; r_sa <= '0; r_da <= '0; r_ipsum <= '0;
            r_tcpsum <= '0; r_thw <= '0; r_ports <= '0; r_held <= '0;
        end else if (accept) begin
            if (i_last) begin
                r_cnt <= '0; r_fwl <= '0; r_eth <= '0; r_ihl <= '0; r_tot <= '0;
                r_frag <= '0; r_proto <= '0; r_sa <= '0; r_da <= '0; r_ipsum <= '0;
                r_tcpsum <= '0; r_thw <= '0; r_ports <= '0; r_held <= '0;
            end else begin
                r_cnt <= n_cnt; r_fwl <= n_fwl; r_eth <= n_eth; r_ihl <= n_ihl;
                r_tot <= n_tot; r_frag <= n_frag; r_proto <= n_proto; r_sa <= n_sa;
                r_da <= n_da; r_ipsum <= n_ipsum; r_tcpsum <= n_tcpsum; r_thw <= n_thw;
                r_ports <= n_ports; r_held <= n_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (accept && i_last) begin
            r_snap_valid <= 1'b1;
        end else if (i_adv) begin
            r_snap_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_last) begin
            r_snap.cap        <= n_cnt;
            r_snap.wire_len   <= n_fwl;
            r_snap.ether_kind <= n_eth;
            r_snap.ihl        <= n_ihl;
            r_snap.total_len  <= n_tot;
            r_snap.frag_word  <= n_frag;
            r_snap.proto      <= n_proto;
            r_snap.src_addr   <= n_sa;
            r_snap.dst_addr   <= n_da;
            r_snap.ip_sum     <= n_ipsum;
            r_snap.tcp_sum    <= n_tcpsum;
            r_snap.thw        <= n_thw;
            r_snap.ports      <= n_ports;
            r_snap.held       <= n_held;
        end
    end

endmodule

[rtl/eitc_verdict.sv]
// Frame verdict logic from the captured snapshot, and the result register.
`timescale 1ns / 1ps
module eitc_verdict (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_snap_valid,
    input  eitc_pkg::t_snap   i_snap,
    input  logic              i_ip_en,
    input  logic              i_tcp_en,
    input  logic              i_m_ready,
    output logic              o_adv,
    output logic              o_valid,
    output eitc_pkg::t_result o_res
);
    import eitc_pkg::*;

    logic             r_valid;
    t_result          r_res, n_res;

    logic [CNT_W-1:0] len;
    logic [CNT_W-1:0] hlen;
    logic [CNT_W-1:0] thl;
    logic [CNT_W-1:0] tl;
    logic [12:0]      off;
    logic             mf;
    logic             frag_ok;
    logic [15:0]      pad;
    logic [18:0]      tsum;
    logic [16:0]      fold1;
    logic [16:0]      fold2;

    assign o_adv   = !r_valid || i_m_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        len  = (i_snap.cap >= ETH_HDR_BYTES) ? i_snap.cap - ETH_HDR_BYTES : '0;
        hlen = {11'd0, i_snap.ihl, 2'b00};
        thl  = {11'd0, i_snap.thw, 2'b00};
        tl   = len - hlen;
        off  = i_snap.frag_word[12:0];
        mf   = i_snap.frag_word[13];
        // Pseudo-header and odd trailing byte folded into the segment sum.
        pad  = tl[0] ? {i_snap.held, 8'd0} : 16'd0;
        tsum = {3'd0, i_snap.tcp_sum} + {3'd0, pad}
             + {3'd0, i_snap.src_addr[31:16]} + {3'd0, i_snap.src_addr[15:0]}
             + {3'd0, i_snap.dst_addr[31:16]} + {3'd0, i_snap.dst_addr[15:0]}
             + {11'd0, i_snap.proto} + {3'd0, tl[15:0]};
        fold1 = {1'b0, tsum[15:0]} + {14'd0, tsum[18:16]};
        fold2 = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};

        n_res   = '0;
        frag_ok = 1'b0;
        priority if (i_snap.cap > i_snap.wire_len) begin
            n_res.status = ST_CAP_GT_WIRE;
        end else if (i_snap.cap < ETH_HDR_BYTES) begin
            n_res.status = ST_SHORT_ETH;
        end else if (i_snap.ether_kind != ETHERTYPE_IPV4) begin
            n_res.status = ST_NOT_IPV4;
        end else if (len < MIN_HDR_BYTES) begin
            n_res.status = ST_SHORT_IP;
        end else if (hlen < MIN_HDR_BYTES || hlen > len) begin
            n_res.status = ST_BAD_IHL;
        end else if ({1'b0, i_snap.total_len} != len) begin
            n_res.status = ST_LEN_MISMATCH;
        end else if (i_snap.src_addr == i_snap.dst_addr) begin
            n_res.status = ST_LAND;
        end else if (i_snap.src_addr[31:24] == LOOPBACK_NET
                     || i_snap.dst_addr[31:24] == LOOPBACK_NET) begin
            n_res.status = ST_LOOPBACK;
        end else if (i_ip_en && i_snap.ip_sum != CSUM_GOOD) begin
            n_res.status = ST_IP_CSUM;
        end else begin
            frag_ok = 1'b1;
            // A first fragment of UDP is handled as unfragmented, then refused.
            priority if ((off != '0 || mf) && !(off == '0 && i_snap.proto == PROTO_UDP)) begin
                n_res.status  = ST_FRAG_OK;
                n_res.pay_off = ETH_HDR_BYTES + hlen;
                n_res.pay_len = tl[15:0];
            end else if (i_snap.proto != PROTO_TCP) begin
                n_res.status = ST_UNSUPP_PROTO;
            end else if (tl < MIN_HDR_BYTES) begin
                n_res.status = ST_SHORT_TCP;
            end else if (thl < MIN_HDR_BYTES) begin
                n_res.status = ST_BAD_OFFSET;
            end else if (thl > tl) begin
                n_res.status = ST_OFFSET_GT_LEN;
            end else if (i_tcp_en && fold2[15:0] != CSUM_GOOD) begin
                n_res.status = ST_TCP_CSUM;
            end else begin
                n_res.status   = ST_TCP_OK;
                n_res.src_port = i_snap.ports[31:16];
                n_res.dst_port = i_snap.ports[15:0];
                n_res.pay_off  = ETH_HDR_BYTES + hlen + thl;
                n_res.pay_len  = tl[15:0] - thl[15:0];
            end
        end
        if (frag_ok) begin
            n_res.frag_off   = off;
            n_res.rsv_flag   = i_snap.frag_word[15];
            n_res.dont_frag  = i_snap.frag_word[14];
            n_res.more_frag  = mf;
            n_res.fragmented = (off != '0) || mf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_snap_valid) begin
            r_res <= n_res;
        end
    end

endmodule

[rtl/eth_ipv4_tcp_header_check_top.sv]
// Top level of the Ethernet/IPv4/TCP header checker: ports, configuration and assertions.
`timescale 1ns / 1ps
// Usage
// The slave stream carries one captured frame byte per word, from the destination
// address onwards, with the wire length alongside and tlast on the final byte.
// Every byte updates the captured header fields and running checksums, so a word is
// taken in every cycle while s_axis_tready is high. A word with tlast produces one
// verdict word on the master stream; other words produce nothing.
// The last byte's fields go into the snapshot register, and the verdict logic then
// writes its result from the snapshot into the result register.
// If the receiver stalls, one finished verdict waits in the result register and a
// second in the snapshot register; while the snapshot register is occupied and the
// result register cannot move on, s_axis_tready is low for every byte, last or not.
// The configuration channel is always ready; registers are the two checksum enables
// and should be written while no frame is in progress.
// Synchronous active-low reset empties both registers, clears the frame state and
// sets both checksum enables.
module eth_ipv4_tcp_header_check_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [eitc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // data_byte[7:0], wire_length[24:8]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[3:0], source_port[19:4], dest_port[35:20], fragment_offset[48:36],
    // reserved_flag[49], dont_fragment[50], more_fragments[51], fragmented[52],
    // payload_offset[69:53], payload_length[85:70]
    output logic [eitc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [eitc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic        i_cfg_data
);
    import eitc_pkg::*;

    logic    r_ip_en;
    logic    r_tcp_en;
    logic    adv;
    logic    snap_valid;
    t_snap   snap;
    t_result res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ip_en  <= 1'b1;
            r_tcp_en <= 1'b1;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_IP_CSUM_EN) begin
                r_ip_en <= i_cfg_data;
            end
            if (i_cfg_index == CFG_TCP_CSUM_EN) begin
                r_tcp_en <= i_cfg_data;
            end
        end
    end

    eitc_hdr_acc u_acc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .i_byte       (s_axis_tdata[7:0]),
        .i_wire_len   (s_axis_tdata[24:8]),
        .i_last       (s_axis_tlast),
        .i_adv        (adv),
        .o_ready      (s_axis_tready),
        .o_snap_valid (snap_valid),
        .o_snap       (snap)
    );

    eitc_verdict u_verdict (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (snap_valid),
        .i_snap       (snap),
        .i_ip_en      (r_ip_en),
        .i_tcp_en     (r_tcp_en),
        .i_m_ready    (m_axis_tready),
        .o_adv        (adv),
        .o_valid      (m_axis_tvalid),
        .o_res        (res)
    );

    assign m_axis_tdata = {2'b00, res.pay_len, res.pay_off, res.fragmented, res.more_frag,
                           res.dont_frag, res.rsv_flag, res.frag_off, res.dst_port,
                           res.src_port, res.status};

    // Ports are reported only for an accepted TCP segment.
    a_ports_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && res.status != ST_TCP_OK) |-> (res.src_port == '0 && res.dst_port == '0))
        else $error("ports nonzero on a rejected frame");

    a_frag_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (res.fragmented == (res.frag_off != '0 || res.more_frag)))
        else $error("fragmented flag inconsistent with offset and MF");

    a_tcp_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && res.status == ST_TCP_OK) |-> (res.pay_off >= 17'd54))
        else $error("TCP payload offset below minimum headers");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (snap_valid && !adv) |-> !s_axis_tready)
        else $error("input accepted while both verdict places are full");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid straight after reset");

endmodule

[bench/testbench.sv]
// Self-checking bench for the Ethernet/IPv4/TCP header checker, with a built-in verdict predictor.
`timescale 1ns / 1ps
module testbench;
    import eitc_pkg::*;

    localparam int LIMIT = 1_000_000;
    localparam int IDLE_PCT = 23;
    localparam int RAND_BYTES = 1950;

    typedef enum logic [1:0] { PK_BYTE, PK_PAUSE, PK_CFG } t_pend_kind;
    typedef struct {
        t_pend_kind  kind;
        logic [7:0]  b;
        logic [16:0] wl;
        logic        lst;
        logic [7:0]  idx;
        logic        val;
    } t_pend;

    typedef enum int {
        FK_TCP_GOOD, FK_TCP_ODD, FK_FRAG, FK_UDP_FIRST, FK_UDP, FK_CAP_GT_WIRE,
        FK_SHORT_ETH, FK_NOT_IPV4, FK_SHORT_IP, FK_IHL_LOW, FK_IHL_LONG,
        FK_LEN_MISMATCH, FK_LAND, FK_LOOPBACK, FK_IP_CSUM, FK_SHORT_TCP,
        FK_THW_LOW, FK_THW_LONG, FK_TCP_CSUM, FK_NOISE
    } t_frame_kind;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic        i_cfg_data;

    eth_ipv4_tcp_header_check_top i_dut (.*);

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // Predictor state: configuration and the per-frame capture.
    logic        ip_csum_en, tcp_csum_en;
    logic [16:0] nbytes, wire_first;
    logic [15:0] eth_kind, tot_len, frag_w;
    logic [3:0]  ihw, thw;
    logic [7:0]  proto, held;
    logic [31:0] src_a, dst_a, ipsum, tcpsum, ports;

    t_result verdicts_due[$];
    t_pend   pending[$];
    logic [7:0] fb[$];

    int cycles = 0, quiet = 0, n_bytes = 0, n_frames = 0, n_cfg = 0;
    int errors = 0, pushed = 0;
    int st_seen[16];
    bit s_acc = 0, c_acc = 0, hold_done = 0;
    int hold_left = 0;

    function automatic logic [31:0] csum_add(input logic [31:0] s, input logic [31:0] w);
        logic [31:0] t;
        t = s + (w & 32'hFFFF);
        return (t & 32'hFFFF) + (t >> 16);
    endfunction

    function automatic logic [15:0] csum_fold(input logic [31:0] s);
        s = (s & 32'hFFFF) + (s >> 16);
        s = (s & 32'hFFFF) + (s >> 16);
        return s[15:0];
    endfunction

    task automatic clear_capture();
        nbytes = 0; wire_first = 0; eth_kind = 0; ihw = 0; tot_len = 0; frag_w = 0;
        proto = 0; src_a = 0; dst_a = 0; ipsum = 0; tcpsum = 0; thw = 0; ports = 0;
        held = 0;
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic [16:0] wl, input logic lst);
        logic [31:0] n, hlen, t, cap, len, tl, s, off, mf;
        t_result r;
        bit frag_ok;
        n = nbytes;
        if (n == 0) wire_first = wl;
        if (n == 12 || n == 13) eth_kind = {eth_kind[7:0], b};
        if (n == 14) ihw = b[3:0];
        if (n == 16 || n == 17) tot_len = {tot_len[7:0], b};
        if (n == 20 || n == 21) frag_w = {frag_w[7:0], b};
        if (n == 23) proto = b;
        if (n >= 26 && n <= 29) src_a = {src_a[23:0], b};
        if (n >= 30 && n <= 33) dst_a = {dst_a[23:0], b};
        hlen = ihw * 4;
        if (n >= 14 && n >= 14 + hlen) begin
            t = n - 14 - hlen;
            if (t < 4) ports = {ports[23:0], b};
            if (t == 12) thw = b[7:4];
        end
        if (n[0]) begin
            if (n >= 14 && n - 14 < hlen) ipsum = csum_add(ipsum, {held, b});
            else if (n >= 14 + hlen) tcpsum = csum_add(tcpsum, {held, b});
        end else begin
            held = b;
        end
        nbytes = (n < 32'h1FFFF) ? 17'(n + 1) : 17'(n);
        if (!lst) return;

        r = '0;
        frag_ok = 0;
        cap = nbytes;
        len = (cap >= 14) ? cap - 14 : 0;
        if (cap > wire_first) r.status = ST_CAP_GT_WIRE;
        else if (cap < 14) r.status = ST_SHORT_ETH;
        else if (eth_kind != ETHERTYPE_IPV4) r.status = ST_NOT_IPV4;
        else if (len < 20) r.status = ST_SHORT_IP;
        else if (hlen < 20 || hlen > len) r.status = ST_BAD_IHL;
        else if (tot_len != len) r.status = ST_LEN_MISMATCH;
        else if (src_a == dst_a) r.status = ST_LAND;
        else if (src_a[31:24] == LOOPBACK_NET || dst_a[31:24] == LOOPBACK_NET)
            r.status = ST_LOOPBACK;
        else if (ip_csum_en && csum_fold(ipsum) != CSUM_GOOD) r.status = ST_IP_CSUM;
        else begin
            off = frag_w & 16'h1FFF;
            mf = frag_w[13];
            tl = len - hlen;
            frag_ok = 1;
            if ((off != 0 || mf != 0) && !(off == 0 && proto == PROTO_UDP)) begin
                r.status = ST_FRAG_OK;
                r.pay_off = 17'(14 + hlen);
                r.pay_len = tl[15:0];
            end else if (proto != PROTO_TCP) r.status = ST_UNSUPP_PROTO;
            else if (tl < 20) r.status = ST_SHORT_TCP;
            else if (thw * 4 < 20) r.status = ST_BAD_OFFSET;
            else if (thw * 4 > tl) r.status = ST_OFFSET_GT_LEN;
            else begin
                s = tcpsum;
                if (tl[0]) s = csum_add(s, {held, 8'h00});
                s = csum_add(s, src_a >> 16);
                s = csum_add(s, src_a);
                s = csum_add(s, dst_a >> 16);
                s = csum_add(s, dst_a);
                s = csum_add(s, proto);
                s = csum_add(s, tl);
                if (tcp_csum_en && csum_fold(s) != CSUM_GOOD) r.status = ST_TCP_CSUM;
                else begin
                    r.status = ST_TCP_OK;
                    r.src_port = ports[31:16];
                    r.dst_port = ports[15:0];
                    r.pay_off = 17'(14 + hlen + thw * 4);
                    r.pay_len = 16'(tl - thw * 4);
                end
            end
        end
        if (frag_ok) begin
            r.frag_off = frag_w[12:0];
            r.rsv_flag = frag_w[15];
            r.dont_frag = frag_w[14];
            r.more_frag = frag_w[13];
            r.fragmented = (frag_w[12:0] != 0) || frag_w[13];
        end
        verdicts_due.push_back(r);
        clear_capture();
    endtask

    // Monitor and predictor both run on the rising edge.
    always @(posedge i_clk) begin
        t_result act, want;
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("eth_ipv4_tcp_header_check_top: mismatch");
            $finish;
        end else if (i_rst_n) begin
            s_acc = s_axis_tvalid && s_axis_tready;
            c_acc = i_cfg_valid && o_cfg_ready;
            if (s_acc) begin
                n_bytes++;
                predict_byte(s_axis_tdata[7:0], s_axis_tdata[24:8], s_axis_tlast);
            end
            if (c_acc) begin
                n_cfg++;
                if (i_cfg_index == CFG_IP_CSUM_EN) ip_csum_en = i_cfg_data;
                else if (i_cfg_index == CFG_TCP_CSUM_EN) tcp_csum_en = i_cfg_data;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                act.status = t_status'(m_axis_tdata[3:0]);
                act.src_port = m_axis_tdata[19:4];
                act.dst_port = m_axis_tdata[35:20];
                act.frag_off = m_axis_tdata[48:36];
                act.rsv_flag = m_axis_tdata[49];
                act.dont_frag = m_axis_tdata[50];
                act.more_frag = m_axis_tdata[51];
                act.fragmented = m_axis_tdata[52];
                act.pay_off = m_axis_tdata[69:53];
                act.pay_len = m_axis_tdata[85:70];
                if (verdicts_due.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected verdict %p", act);
                end else begin
                    want = verdicts_due.pop_front();
                    n_frames++;
                    st_seen[want.status]++;
                    if (act != want) begin
                        errors++;
                        if (errors <= 10)
                            $display("verdict %0d differs: expected %p, actual %p",
                                     n_frames, want, act);
                    end
                end
            end
            if (s_acc || verdicts_due.size() != 0 || m_axis_tvalid) quiet = 0;
            else quiet++;
        end
    end

    function automatic bit calm();
        return n_bytes >= 1000 && n_bytes < 1300;
    endfunction

    // Sender: one pending word at a time; pauses and register writes wait for quiet.
    always @(negedge i_clk) begin
        logic nv, cv;
        t_pend h;
        if (i_rst_n) begin
            nv = s_axis_tvalid && !s_acc;
            cv = i_cfg_valid && !c_acc;
            s_acc = 0;
            c_acc = 0;
            if (!nv && !cv && pending.size() > 0) begin
                h = pending[0];
                case (h.kind)
                    PK_BYTE: if (calm() || $urandom_range(99) >= IDLE_PCT) begin
                        void'(pending.pop_front());
                        s_axis_tdata <= {7'd0, h.wl, h.b};
                        s_axis_tlast <= h.lst;
                        nv = 1;
                    end
                    PK_PAUSE: if (verdicts_due.size() == 0 && quiet >= 8)
                        void'(pending.pop_front());
                    PK_CFG: if (verdicts_due.size() == 0 && quiet >= 8) begin
                        void'(pending.pop_front());
                        i_cfg_index <= h.idx;
                        i_cfg_data <= h.val;
                        cv = 1;
                    end
                    default: ;
                endcase
            end
            s_axis_tvalid <= nv;
            i_cfg_valid <= cv;
        end
    end

    // Receiver: random stalls, one long hold-off, and a calm stretch.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!hold_done && n_bytes >= 500) begin
                hold_done = 1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm() || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    task automatic put16(input int pos, input logic [15:0] v);
        fb[pos] = v[15:8];
        fb[pos+1] = v[7:0];
    endtask

    function automatic int ip_hlen();
        return fb[14][3:0] * 4;
    endfunction

    task automatic ip_csum();
        logic [31:0] s;
        int hl;
        hl = ip_hlen();
        if (hl > fb.size() - 14) hl = fb.size() - 14;
        put16(24, 16'h0);
        s = 0;
        for (int i = 0; i < hl; i += 2)
            s = csum_add(s, {fb[14+i], (i + 1 < hl) ? fb[15+i] : 8'h00});
        put16(24, ~csum_fold(s));
    endtask

    task automatic tcp_fix();
        logic [31:0] s;
        int st, tl;
        st = 14 + ip_hlen();
        tl = fb.size() - st;
        put16(st + 16, 16'h0);
        s = 0;
        for (int i = 0; i < tl; i += 2)
            s = csum_add(s, {fb[st+i], (i + 1 < tl) ? fb[st+i+1] : 8'h00});
        for (int i = 26; i < 34; i += 2) s = csum_add(s, {fb[i], fb[i+1]});
        s = csum_add(s, fb[23]);
        s = csum_add(s, tl);
        put16(st + 16, ~csum_fold(s));
    endtask

    task automatic build_tcp(input int ihl, input int tw, input int plen,
                             input logic [7:0] pr, input logic [15:0] fw);
        fb.delete();
        repeat (12) fb.push_back(8'($urandom));
        fb.push_back(8'h08); fb.push_back(8'h00);
        fb.push_back({4'h4, 4'(ihl)});
        fb.push_back(8'($urandom));
        repeat (4) fb.push_back(8'($urandom));
        fb.push_back(fw[15:8]); fb.push_back(fw[7:0]);
        fb.push_back(8'($urandom));
        fb.push_back(pr);
        repeat (10) fb.push_back(8'($urandom));
        repeat (ihl * 4 - 20) fb.push_back(8'($urandom));
        repeat (12) fb.push_back(8'($urandom));
        fb.push_back({4'(tw), 4'($urandom)});
        repeat (7) fb.push_back(8'($urandom));
        repeat (tw * 4 - 20) fb.push_back(8'($urandom));
        repeat (plen) fb.push_back(8'($urandom));
    endtask

    task automatic push_frame();
        logic [16:0] wl;
        bit vary;
        int sz;
        sz = fb.size();
        wl = 17'(sz);
        case ($urandom_range(15))
            0: wl = 17'h1FFFF;
            1, 2, 3: wl = 17'(sz + $urandom_range(0, 131071 - sz));
            default: ;
        endcase
        vary = ($urandom_range(7) == 0);
        for (int i = 0; i < sz; i++) begin
            t_pend p;
            p.kind = PK_BYTE;
            p.b = fb[i];
            p.wl = (i == 0 || !vary) ? wl : 17'($urandom);
            p.lst = (i == sz - 1);
            pending.push_back(p);
        end
        pushed += sz;
    endtask

    task automatic make_frame(input t_frame_kind k);
        int ihl, tw, plen, hl, cut;
        logic [7:0] pr;
        logic [15:0] fw;
        ihl = ($urandom_range(3) == 0) ? $urandom_range(6, 15) : 5;
        tw = ($urandom_range(3) == 0) ? $urandom_range(6, 15) : 5;
        plen = ($urandom_range(7) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 12);
        pr = PROTO_TCP;
        fw = {1'($urandom_range(7) == 0), 1'($urandom), 14'd0};
        case (k)
            FK_TCP_ODD: plen = 2 * $urandom_range(0, 6) + 1;
            FK_FRAG: begin
                fw[12:0] = 13'($urandom);
                fw[13] = (fw[12:0] == 0) ? 1'b1 : 1'($urandom);
                pr = $urandom_range(1) ? PROTO_TCP : 8'($urandom);
            end
            FK_UDP_FIRST: begin pr = PROTO_UDP; fw[13] = 1'b1; end
            FK_UDP: begin
                pr = $urandom_range(1) ? PROTO_UDP : 8'($urandom);
                if (pr == PROTO_TCP) pr = 8'd1;
            end
            FK_IHL_LONG, FK_THW_LONG: begin ihl = 5; tw = 5; plen = $urandom_range(0, 10); end
            default: ;
        endcase
        build_tcp(ihl, tw, plen, pr, fw);
        hl = ip_hlen();
        case (k)
            FK_TCP_GOOD: if ($urandom_range(7) == 0) fb[14][7:4] = 4'($urandom);
            FK_SHORT_ETH: fb = fb[0:$urandom_range(0, 12)];
            FK_NOT_IPV4: begin
                put16(12, 16'($urandom));
                if (fb[12] == 8'h08 && fb[13] == 8'h00) fb[13] = 8'h06;
            end
            FK_SHORT_IP: fb = fb[0:13 + $urandom_range(0, 19)];
            FK_IHL_LOW: fb[14][3:0] = 4'($urandom_range(0, 4));
            FK_IHL_LONG: fb[14][3:0] = 4'hF;
            FK_LAND: for (int i = 0; i < 4; i++) fb[30+i] = fb[26+i];
            FK_LOOPBACK: fb[$urandom_range(1) ? 26 : 30] = LOOPBACK_NET;
            FK_SHORT_TCP: begin
                cut = 14 + hl + $urandom_range(0, 19);
                fb = fb[0:cut-1];
            end
            FK_THW_LOW: fb[14+hl+12][7:4] = 4'($urandom_range(0, 4));
            FK_THW_LONG: fb[14+hl+12][7:4] = 4'hF;
            FK_NOISE: begin
                fb.delete();
                repeat ($urandom_range(1, 70)) fb.push_back(8'($urandom));
                if (fb.size() > 14 && $urandom_range(1)) begin
                    fb[12] = 8'h08; fb[13] = 8'h00;
                end
            end
            default: ;
        endcase
        if (k != FK_NOISE && fb.size() > 14) begin
            hl = ip_hlen();
            if (hl >= 20 && fb.size() >= 14 + hl + 18) tcp_fix();
            if (fb.size() >= 26) begin
                put16(16, 16'(fb.size() - 14));
                ip_csum();
            end
        end
        case (k)
            FK_LEN_MISMATCH: begin
                put16(16, {fb[16], fb[17]} + 16'($urandom_range(1, 300)) *
                          ($urandom_range(1) ? 16'hFFFF : 16'h1));
                ip_csum();
            end
            FK_IP_CSUM: fb[14 + $urandom_range(10, hl - 1)] ^= 8'(1 << $urandom_range(7));
            FK_TCP_CSUM: begin
                cut = $urandom_range(14 + hl, fb.size() - 1);
                fb[cut] ^= 8'(1 << $urandom_range(7));
            end
            default: ;
        endcase
        if (k == FK_CAP_GT_WIRE) begin
            push_frame();
            // Report a wire length shorter than the capture on every byte.
            for (int i = pending.size() - fb.size(); i < pending.size(); i++)
                pending[i].wl = 17'(fb.size() - 1 - $urandom_range(0, fb.size() - 1));
        end else begin
            push_frame();
        end
    endtask

    task automatic add_cfg(input logic [7:0] idx, input logic v);
        t_pend p;
        p = '{kind: PK_CFG, b: 0, wl: 0, lst: 0, idx: idx, val: v};
        pending.push_back(p);
    endtask

    initial begin
        t_pend p;
        int nf, nonzero;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = 1'b0;
        ip_csum_en = 1'b1;
        tcp_csum_en = 1'b1;
        clear_capture();

        // Directed part: each frame shape once with both checks on, then the
        // checksum-sensitive shapes again with both checks off.
        for (int k = FK_TCP_GOOD; k <= FK_NOISE; k++) make_frame(t_frame_kind'(k));
        add_cfg(CFG_IP_CSUM_EN, 1'b0);
        add_cfg(CFG_TCP_CSUM_EN, 1'b0);
        make_frame(FK_IP_CSUM);
        make_frame(FK_TCP_CSUM);
        add_cfg(CFG_IP_CSUM_EN, 1'b1);
        add_cfg(CFG_TCP_CSUM_EN, 1'b1);

        nf = 0;
        while (pushed < RAND_BYTES) begin
            if ($urandom_range(1)) make_frame($urandom_range(1) ? FK_TCP_GOOD : FK_TCP_ODD);
            else make_frame(t_frame_kind'($urandom_range(FK_TCP_GOOD, FK_NOISE)));
            nf++;
            if (nf % 12 == 0) begin
                add_cfg(CFG_IP_CSUM_EN, 1'($urandom));
                add_cfg(CFG_TCP_CSUM_EN, 1'($urandom));
            end
            if (nf == 20) begin
                p.kind = PK_PAUSE;
                pending.push_back(p);
            end
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || s_axis_tvalid || i_cfg_valid) @(posedge i_clk);
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        nonzero = 0;
        for (int i = 0; i < 16; i++) if (st_seen[i] != 0) nonzero++;
        $display("checked %0d verdicts over %0d bytes, %0d register writes", n_frames,
                 n_bytes, n_cfg);
        $display("%0d of 16 verdict codes seen, %0d mismatches", nonzero, errors);
        if (errors == 0 && verdicts_due.size() == 0) begin
            $display("eth_ipv4_tcp_header_check_top: match");
        end else begin
            $display("eth_ipv4_tcp_header_check_top: mismatch");
        end
        $finish;
    end

endmodule
